@@ rtl/icp_pkg.sv @@
// Shared types and constants of the intcode processor.
// Holds the word widths, event codes, opcode decode type and the command and
// status structs that join the controller to the datapath. No dependencies.
package icp_pkg;

    localparam int DEF_MEM_DEPTH = 4096;
    localparam int ADDR_W        = 12;
    localparam int WORD_W        = 64;
    localparam int EVENT_W       = 3;

    // A run that executes this many instructions without stopping is an error.
    localparam int RUN_BUDGET = 1048576;
    localparam int CNT_W      = $clog2(RUN_BUDGET) + 1;

    localparam logic [EVENT_W-1:0] EV_OUTPUT     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_NEED_INPUT = 3'd1;
    localparam logic [EVENT_W-1:0] EV_HALTED     = 3'd2;
    localparam logic [EVENT_W-1:0] EV_ERROR      = 3'd3;
    localparam logic [EVENT_W-1:0] EV_LOADED     = 3'd4;

    typedef enum logic [3:0] {
        OP_BAD,
        OP_ADD,
        OP_MUL,
        OP_IN,
        OP_OUT,
        OP_JT,
        OP_JF,
        OP_LT,
        OP_EQ,
        OP_ARB,
        OP_HALT
    } opcode_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_RD_IP,
        MEM_RD_SLOT,
        MEM_RD_PTR,
        MEM_WR_LOAD,
        MEM_WR_RES,
        MEM_WR_IN,
        MEM_WR_ZERO
    } mem_cmd_t;

    typedef enum logic [2:0] {
        IP_HOLD,
        IP_ADV2,
        IP_ADV3,
        IP_ADV4,
        IP_JUMP
    } ip_cmd_t;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_ADD,
        ALU_LT,
        ALU_EQ,
        ALU_MUL0,
        ALU_MUL1,
        ALU_MUL2
    } alu_cmd_t;

    typedef struct packed {
        mem_cmd_t           mem;
        ip_cmd_t            ip;
        alu_cmd_t           alu;
        logic [1:0]         param;
        logic               take_item;
        logic               capture_w;
        logic               bcd_step;
        logic               capture_ptr;
        logic               capture_a;
        logic               capture_b;
        logic               set_fed;
        logic               rb_add;
        logic               set_halt;
        logic               set_error;
        logic               cnt_inc;
        logic               out_load;
        logic [EVENT_W-1:0] out_event;
    } cmd_t;

    typedef struct packed {
        logic    clear_last;
        logic    halted;
        logic    error;
        logic    fed;
        logic    budget_done;
        logic    ip_oob;
        logic    bcd_last;
        logic    w_neg;
        opcode_t opcode;
        logic    slot_oob;
        logic    mode_bad;
        logic    ptr_oob;
        logic    jump_taken;
        logic    b_oob;
        logic    out_busy;
    } sts_t;

endpackage

@@ rtl/icp_if.sv @@
// Valid/ready channel interfaces of the intcode processor.
// Depends on icp_pkg for the payload widths.
interface icp_in_if;
    import icp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [ADDR_W-1:0]        address;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output mode, output address, output value, input ready);
    modport sink (input valid, input mode, input address, input value, output ready);
endinterface

interface icp_out_if;
    import icp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [EVENT_W-1:0]       event_res;
    logic signed [WORD_W-1:0] value_res;

    modport source (output valid, output event_res, output value_res, input ready);
    modport sink (input valid, input event_res, input value_res, output ready);
endinterface

@@ rtl/icp_datapath.sv @@
// Datapath of the intcode processor: word memory, architectural registers,
// decimal digit extraction, operand addressing, ALU and the output register.
// Depends on icp_pkg; driven by icp_controller through cmd_t.
module icp_datapath #(
    parameter int MEM_DEPTH = icp_pkg::DEF_MEM_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  icp_pkg::cmd_t                cmd,
    output icp_pkg::sts_t                sts,
    input  logic [icp_pkg::ADDR_W-1:0]   in_address,
    input  logic [icp_pkg::WORD_W-1:0]   in_value,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [icp_pkg::EVENT_W-1:0]  out_event,
    output logic [icp_pkg::WORD_W-1:0]   out_value
);
    import icp_pkg::*;

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int IPW = AW + 1;
    localparam int SW  = AW + 2;

    logic [WORD_W-1:0] mem [MEM_DEPTH];

    logic [WORD_W-1:0]  rdata_reg;
    logic [WORD_W-1:0]  sh_reg;
    logic               w_neg_reg;
    logic [19:0]        bcd_reg;
    logic [3:0]         bcd_cnt_reg;
    logic [WORD_W-1:0]  a_reg;
    logic [WORD_W-1:0]  b_reg;
    logic [WORD_W-1:0]  res_reg;
    logic [AW-1:0]      ptr_reg;
    logic [WORD_W-1:0]  in_val_reg;
    logic [IPW-1:0]     ip_reg;
    logic [IPW-1:0]     ip_next;
    logic [WORD_W-1:0]  rb_reg;
    logic               halted_reg;
    logic               error_reg;
    logic               fed_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [AW-1:0]      clr_reg;
    logic               out_valid_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic [WORD_W-1:0]  out_value_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic               load_ok;
    logic [SW-1:0]      slot;
    logic [3:0]         mode_dig;
    logic [WORD_W-1:0]  ptr_val;
    logic [31:0]        mul_x;
    logic [31:0]        mul_y;
    logic [WORD_W-1:0]  prod;
    opcode_t            opcode;

    // Four bits of binary-to-BCD conversion per call; carries out of the
    // fifth digit are dropped, which keeps the value modulo 100000.
    function automatic logic [19:0] dabble4(logic [19:0] v, logic [3:0] bits);
        logic [19:0] t;
        int i;
        int j;
        t = v;
        for (i = 3; i >= 0; i--)
        begin
            for (j = 0; j < 5; j++)
            begin
                if (t[4*j +: 4] >= 4'd5)
                    t[4*j +: 4] = t[4*j +: 4] + 4'd3;
            end
            t = {t[18:0], bits[i]};
        end
        return t;
    endfunction

    assign load_ok = 32'(in_address) < 32'(MEM_DEPTH);
    assign slot    = SW'(ip_reg) + SW'(cmd.param);

    always_comb
    begin
        case (cmd.param)
            2'd1:    mode_dig = bcd_reg[11:8];
            2'd2:    mode_dig = bcd_reg[15:12];
            2'd3:    mode_dig = bcd_reg[19:16];
            default: mode_dig = 4'd0;
        endcase
    end

    always_comb
    begin
        case (mode_dig)
            4'd1:    ptr_val = WORD_W'(slot);
            4'd2:    ptr_val = rdata_reg + rb_reg;
            default: ptr_val = rdata_reg;
        endcase
    end

    always_comb
    begin
        if (bcd_reg[7:4] == 4'd0)
        begin
            case (bcd_reg[3:0])
                4'd1:    opcode = OP_ADD;
                4'd2:    opcode = OP_MUL;
                4'd3:    opcode = OP_IN;
                4'd4:    opcode = OP_OUT;
                4'd5:    opcode = OP_JT;
                4'd6:    opcode = OP_JF;
                4'd7:    opcode = OP_LT;
                4'd8:    opcode = OP_EQ;
                4'd9:    opcode = OP_ARB;
                default: opcode = OP_BAD;
            endcase
        end
        else if (bcd_reg[7:0] == 8'h99)
            opcode = OP_HALT;
        else
            opcode = OP_BAD;
    end

    // Memory port selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = res_reg;
        mem_raddr = ip_reg[AW-1:0];
        case (cmd.mem)
            MEM_RD_SLOT: mem_raddr = slot[AW-1:0];
            MEM_RD_PTR:  mem_raddr = ptr_val[AW-1:0];
            MEM_WR_LOAD:
            begin
                mem_we    = load_ok;
                mem_waddr = AW'(in_address);
                mem_wdata = in_value;
            end
            MEM_WR_RES:  mem_we = 1'b1;
            MEM_WR_IN:
            begin
                mem_we    = 1'b1;
                mem_wdata = in_val_reg;
            end
            MEM_WR_ZERO:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            default: mem_raddr = ip_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // One 32x32 multiplier; the 64-bit wrapped product takes three passes.
    always_comb
    begin
        case (cmd.alu)
            ALU_MUL1:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            ALU_MUL2:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
            default:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
        endcase
        prod = WORD_W'(mul_x) * WORD_W'(mul_y);
    end

    always_comb
    begin
        case (cmd.ip)
            IP_ADV2: ip_next = ip_reg + IPW'(2);
            IP_ADV3: ip_next = ip_reg + IPW'(3);
            IP_ADV4: ip_next = ip_reg + IPW'(4);
            IP_JUMP: ip_next = b_reg[IPW-1:0];
            default: ip_next = ip_reg;
        endcase
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture_w)
        begin
            sh_reg      <= rdata_reg;
            w_neg_reg   <= rdata_reg[WORD_W-1];
            bcd_reg     <= '0;
            bcd_cnt_reg <= '0;
        end
        else if (cmd.bcd_step)
        begin
            bcd_reg     <= dabble4(bcd_reg, sh_reg[WORD_W-1 -: 4]);
            sh_reg      <= {sh_reg[WORD_W-5:0], 4'b0};
            bcd_cnt_reg <= bcd_cnt_reg + 4'd1;
        end
        if (cmd.capture_a)
            a_reg <= rdata_reg;
        if (cmd.capture_b)
            b_reg <= rdata_reg;
        if (cmd.capture_ptr)
            ptr_reg <= ptr_val[AW-1:0];
        if (cmd.take_item)
            in_val_reg <= in_value;
        case (cmd.alu)
            ALU_ADD:  res_reg <= a_reg + b_reg;
            ALU_LT:   res_reg <= WORD_W'($signed(a_reg) < $signed(b_reg));
            ALU_EQ:   res_reg <= WORD_W'(a_reg == b_reg);
            ALU_MUL0: res_reg <= prod;
            ALU_MUL1: res_reg <= res_reg + {prod[31:0], 32'b0};
            ALU_MUL2: res_reg <= res_reg + {prod[31:0], 32'b0};
            default:  res_reg <= res_reg;
        endcase
        if (cmd.out_load)
        begin
            out_event_reg <= cmd.out_event;
            out_value_reg <= (cmd.out_event == EV_OUTPUT) ? a_reg : '0;
        end
    end

    // Architectural and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg        <= '0;
            rb_reg        <= '0;
            halted_reg    <= 1'b0;
            error_reg     <= 1'b0;
            fed_reg       <= 1'b0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ip_reg <= ip_next;
            if (cmd.rb_add)
                rb_reg <= rb_reg + a_reg;
            if (cmd.set_halt || cmd.set_error)
                halted_reg <= 1'b1;
            if (cmd.set_error)
                error_reg <= 1'b1;
            if (cmd.take_item)
            begin
                fed_reg <= 1'b0;
                cnt_reg <= '0;
            end
            else
            begin
                if (cmd.set_fed)
                    fed_reg <= 1'b1;
                if (cmd.cnt_inc)
                    cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.mem == MEM_WR_ZERO)
                clr_reg <= clr_reg + AW'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.clear_last  = clr_reg == AW'(MEM_DEPTH - 1);
        sts.halted      = halted_reg;
        sts.error       = error_reg;
        sts.fed         = fed_reg;
        sts.budget_done = cnt_reg == CNT_W'(RUN_BUDGET);
        sts.ip_oob      = 32'(ip_reg) >= 32'(MEM_DEPTH);
        sts.bcd_last    = bcd_cnt_reg == 4'hF;
        sts.w_neg       = w_neg_reg;
        sts.opcode      = opcode;
        sts.slot_oob    = 32'(slot) >= 32'(MEM_DEPTH);
        sts.mode_bad    = mode_dig > 4'd2;
        sts.ptr_oob     = ptr_val >= WORD_W'(MEM_DEPTH);
        sts.jump_taken  = (opcode == OP_JT) ? (a_reg != '0) : (a_reg == '0);
        sts.b_oob       = b_reg >= WORD_W'(MEM_DEPTH);
        sts.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;
    assign out_value = out_value_reg;

endmodule

@@ rtl/icp_controller.sv @@
// Sequencing state machine of the intcode processor.
// Depends on icp_pkg; steers icp_datapath through cmd_t and reads sts_t.
module icp_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_mode,
    output logic          in_ready,
    input  icp_pkg::sts_t sts,
    output icp_pkg::cmd_t cmd
);
    import icp_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_FETCH    = 13'b0000000000100,
        S_DECODE   = 13'b0000000001000,
        S_DIGITS   = 13'b0000000010000,
        S_DISPATCH = 13'b0000000100000,
        S_SLOT     = 13'b0000001000000,
        S_ADDR     = 13'b0000010000000,
        S_VAL      = 13'b0000100000000,
        S_EXEC     = 13'b0001000000000,
        S_MUL      = 13'b0010000000000,
        S_WRITE    = 13'b0100000000000,
        S_RESP     = 13'b1000000000000
    } state_t;

    typedef enum logic [1:0] {
        TGT_A,
        TGT_B,
        TGT_DST
    } tgt_t;

    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         k_reg;
    logic [1:0]         k_next;
    tgt_t               tgt_reg;
    tgt_t               tgt_next;
    logic [EVENT_W-1:0] ev_reg;
    logic [EVENT_W-1:0] ev_next;
    logic               mul_reg;
    logic               mul_next;
    logic               fail;
    logic               operand_done;
    logic               arith;

    assign arith = (sts.opcode == OP_ADD) || (sts.opcode == OP_MUL) ||
                   (sts.opcode == OP_LT) || (sts.opcode == OP_EQ);

    always_comb
    begin
        cmd          = '0;
        cmd.param    = k_reg;
        in_ready     = 1'b0;
        state_next   = state_reg;
        k_next       = k_reg;
        tgt_next     = tgt_reg;
        ev_next      = ev_reg;
        mul_next     = mul_reg;
        fail         = 1'b0;
        operand_done = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.mem = MEM_WR_ZERO;
                if (sts.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!in_mode)
                    begin
                        cmd.mem    = MEM_WR_LOAD;
                        ev_next    = EV_LOADED;
                        state_next = S_RESP;
                    end
                    else if (sts.error)
                    begin
                        ev_next    = EV_ERROR;
                        state_next = S_RESP;
                    end
                    else if (sts.halted)
                    begin
                        ev_next    = EV_HALTED;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.take_item = 1'b1;
                        state_next    = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (sts.budget_done || sts.ip_oob)
                    fail = 1'b1;
                else
                begin
                    cmd.mem    = MEM_RD_IP;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.capture_w = 1'b1;
                state_next    = S_DIGITS;
            end
            S_DIGITS:
            begin
                cmd.bcd_step = 1'b1;
                if (sts.bcd_last)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (sts.w_neg)
                    fail = 1'b1;
                else
                begin
                    case (sts.opcode)
                        OP_ADD, OP_MUL, OP_LT, OP_EQ, OP_OUT, OP_JT, OP_JF, OP_ARB:
                        begin
                            k_next     = 2'd1;
                            tgt_next   = TGT_A;
                            state_next = S_SLOT;
                        end
                        OP_IN:
                        begin
                            if (sts.fed)
                            begin
                                ev_next    = EV_NEED_INPUT;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                k_next     = 2'd1;
                                tgt_next   = TGT_DST;
                                state_next = S_SLOT;
                            end
                        end
                        OP_HALT:
                        begin
                            cmd.set_halt = 1'b1;
                            ev_next      = EV_HALTED;
                            state_next   = S_RESP;
                        end
                        default: fail = 1'b1;
                    endcase
                end
            end
            S_SLOT:
            begin
                if (sts.slot_oob || sts.mode_bad)
                    fail = 1'b1;
                else
                begin
                    cmd.mem    = MEM_RD_SLOT;
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                if (sts.ptr_oob)
                    fail = 1'b1;
                else
                begin
                    cmd.capture_ptr = 1'b1;
                    if (tgt_reg == TGT_DST)
                        operand_done = 1'b1;
                    else
                    begin
                        cmd.mem    = MEM_RD_PTR;
                        state_next = S_VAL;
                    end
                end
            end
            S_VAL:
            begin
                if (tgt_reg == TGT_A)
                    cmd.capture_a = 1'b1;
                else
                    cmd.capture_b = 1'b1;
                operand_done = 1'b1;
            end
            S_EXEC:
            begin
                case (sts.opcode)
                    OP_ADD:
                    begin
                        cmd.alu    = ALU_ADD;
                        state_next = S_WRITE;
                    end
                    OP_LT:
                    begin
                        cmd.alu    = ALU_LT;
                        state_next = S_WRITE;
                    end
                    OP_EQ:
                    begin
                        cmd.alu    = ALU_EQ;
                        state_next = S_WRITE;
                    end
                    OP_MUL:
                    begin
                        cmd.alu    = ALU_MUL0;
                        mul_next   = 1'b0;
                        state_next = S_MUL;
                    end
                    OP_IN:
                    begin
                        cmd.mem     = MEM_WR_IN;
                        cmd.set_fed = 1'b1;
                        cmd.ip      = IP_ADV2;
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_FETCH;
                    end
                    OP_OUT:
                    begin
                        cmd.ip     = IP_ADV2;
                        ev_next    = EV_OUTPUT;
                        state_next = S_RESP;
                    end
                    OP_JT, OP_JF:
                    begin
                        if (k_reg == 2'd1)
                        begin
                            if (sts.jump_taken)
                            begin
                                k_next     = 2'd2;
                                tgt_next   = TGT_B;
                                state_next = S_SLOT;
                            end
                            else
                            begin
                                cmd.ip      = IP_ADV3;
                                cmd.cnt_inc = 1'b1;
                                state_next  = S_FETCH;
                            end
                        end
                        else if (sts.b_oob)
                            fail = 1'b1;
                        else
                        begin
                            cmd.ip      = IP_JUMP;
                            cmd.cnt_inc = 1'b1;
                            state_next  = S_FETCH;
                        end
                    end
                    OP_ARB:
                    begin
                        cmd.rb_add  = 1'b1;
                        cmd.ip      = IP_ADV2;
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_FETCH;
                    end
                    default: fail = 1'b1;
                endcase
            end
            S_MUL:
            begin
                if (!mul_reg)
                begin
                    cmd.alu  = ALU_MUL1;
                    mul_next = 1'b1;
                end
                else
                begin
                    cmd.alu    = ALU_MUL2;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.mem     = MEM_WR_RES;
                cmd.ip      = IP_ADV4;
                cmd.cnt_inc = 1'b1;
                state_next  = S_FETCH;
            end
            S_RESP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_event = ev_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // After an operand is resolved, arithmetic ops fetch the next one until
        // the destination is resolved; everything else moves on to execution.
        if (operand_done)
        begin
            if (arith && (k_reg != 2'd3))
            begin
                k_next     = k_reg + 2'd1;
                tgt_next   = (k_reg == 2'd2) ? TGT_DST : TGT_B;
                state_next = S_SLOT;
            end
            else
                state_next = S_EXEC;
        end

        if (fail)
        begin
            cmd.set_error = 1'b1;
            ev_next       = EV_ERROR;
            state_next    = S_RESP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            k_reg     <= 2'd0;
            tgt_reg   <= TGT_A;
            ev_reg    <= EV_LOADED;
            mul_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            tgt_reg   <= tgt_next;
            ev_reg    <= ev_next;
            mul_reg   <= mul_next;
        end
    end

endmodule

@@ rtl/intcode_processor_top.sv @@
// Top level of the intcode processor: a 64-bit intcode machine with one
// word memory. Depends on icp_pkg, icp_if, icp_controller and icp_datapath.
//
// Usage. The item channel carries one word per command. With mode 0 the
// word's value is stored at the given address (addresses at or past the
// memory depth store nothing) and the block answers "load done". With mode 1
// the machine resumes at its instruction pointer; the word's value feeds the
// first input instruction of that run. The run stops at an output
// instruction (event 0 with the emitted value), at a second input request
// (event 1, the pointer stays on it), at halt (event 2) or on a fault
// (event 3, the machine then stays stopped). Every item gives one result word.
//
// Timing. Per instruction a run goes through a fetch, a decode step, decimal
// digit extraction (four bits per cycle) and, per operand, a slot read and,
// for a source operand, a value read through the single memory read port;
// a multiply adds its partial-product passes. One item is worked on at a time.
//
// Reset. After reset the memory is cleared one address at a time, and no item
// is accepted until that pass is done. The result word sits in an output
// register; while it is stalled the next item is still taken, and its
// result waits until that register frees up.
module intcode_processor_top #(
    parameter int MEM_DEPTH = icp_pkg::DEF_MEM_DEPTH
) (
    input logic       clk,
    input logic       rst_n,
    icp_in_if.sink    item,
    icp_out_if.source result
);
    import icp_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic               in_ready;
    logic               out_valid;
    logic [EVENT_W-1:0] out_event;
    logic [WORD_W-1:0]  out_value;

    icp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_mode  (item.mode),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    icp_datapath #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_address (item.address),
        .in_value   ($unsigned(item.value)),
        .out_ready  (result.ready),
        .out_valid  (out_valid),
        .out_event  (out_event),
        .out_value  (out_value)
    );

    assign item.ready       = in_ready;
    assign result.valid     = out_valid;
    assign result.event_res = out_event;
    assign result.value_res = $signed(out_value);

endmodule
